// File: rtl/core/ccsw_pkg.sv
package ccsw_pkg;

    // Reflected IEEE 802.3 polynomial, seed and closing XOR
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // Stored CRC field left out of the stream
    localparam int unsigned SKIP_LEN = 4;

    // Configuration register widths
    localparam int unsigned SKIP_W = 40;
    localparam int unsigned CRC_W  = 32;
    localparam int unsigned CFG_W  = 40;

    // Configuration register indexes
    localparam logic REG_SKIP_OFFSET  = 1'b0;
    localparam logic REG_EXPECTED_CRC = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_MATCH    = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_SKIPPED  = 2'd2;

    typedef struct packed {
        logic [31:0] crc_value;
        logic [1:0]  status;
    } ccsw_result_t;

    typedef struct packed {
        logic         valid;
        ccsw_result_t result;
    } ccsw_push_t;

    // Fold one byte into the running CRC, one bit per step
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: rtl/core/ccsw_crc_core.sv
module ccsw_crc_core
    import ccsw_pkg::*;
#(
    parameter int POSITION_BITS = 40
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic [SKIP_W-1:0]   skip_offset,
    input  logic [CRC_W-1:0]    expected_crc,
    input  logic                out_free,
    output ccsw_push_t          push
);

    localparam int CMP_W = (POSITION_BITS > SKIP_W) ? POSITION_BITS : SKIP_W;

    logic                     beat_valid_reg;
    logic [7:0]               beat_data_reg;
    logic                     beat_last_reg;
    logic [31:0]              crc_reg;
    logic [31:0]              crc_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         off_ext;
    logic [CMP_W-1:0]         pos_diff;
    logic                     in_window;
    logic                     advance;
    logic [31:0]              final_crc;

    // Advance the held beat; a last beat needs room in the result stage
    assign advance  = beat_valid_reg && (!beat_last_reg || out_free);
    assign in_ready = !beat_valid_reg || advance;

    // Hold the accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_valid_reg <= 1'b0;
        else if (in_ready)
            beat_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_data_reg <= data_byte;
            beat_last_reg <= last_byte;
        end
    end

    // Window test without wrap-around
    assign pos_ext   = CMP_W'(pos_reg);
    assign off_ext   = CMP_W'(skip_offset);
    assign pos_diff  = pos_ext - off_ext;
    assign in_window = (pos_ext >= off_ext) && (pos_diff < CMP_W'(SKIP_LEN));

    // Fold the byte unless it lies in the window
    always_comb
    begin
        if (in_window)
            crc_next = crc_reg;
        else
            crc_next = crc_byte(crc_reg, beat_data_reg);
    end

    // Saturating position counter
    assign pos_next = (&pos_reg) ? pos_reg : pos_reg + POSITION_BITS'(1);

    // Update state; clear it after the last beat of a file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_ONES;
            pos_reg <= '0;
        end
        else if (advance)
        begin
            if (beat_last_reg)
            begin
                crc_reg <= CRC_ONES;
                pos_reg <= '0;
            end
            else
            begin
                crc_reg <= crc_next;
                pos_reg <= pos_next;
            end
        end
    end

    // Form the result
    assign final_crc = crc_next ^ CRC_ONES;

    always_comb
    begin
        push.valid            = advance && beat_last_reg;
        push.result.crc_value = final_crc;
        if (expected_crc == '0)
            push.result.status = STATUS_SKIPPED;
        else if (final_crc == expected_crc)
            push.result.status = STATUS_MATCH;
        else
            push.result.status = STATUS_MISMATCH;
    end

endmodule

// File: rtl/core/ccsw_out_reg.sv
module ccsw_out_reg
    import ccsw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ccsw_push_t  push,
    output logic        out_free,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] crc_value,
    output logic [1:0]  status
);

    logic         valid_reg;
    ccsw_result_t result_reg;

    // Room when empty or when the held beat leaves this cycle
    assign out_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (out_free)
            valid_reg <= push.valid;
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (out_free && push.valid)
            result_reg <= push.result;
    end

    assign out_valid = valid_reg;
    assign crc_value = result_reg.crc_value;
    assign status    = result_reg.status;

endmodule

// File: rtl/core/crc32_check_with_skip_window.sv
// CRC-32 file check with a skipped four-byte window.
//
// Input channel (in_valid/in_ready): one file byte per beat, data_byte with
// last_byte marking the final byte. Output channel (out_valid/out_ready): one
// beat per file carrying the final CRC (closing XOR applied) and a status of
// match, mismatch or skipped (expected CRC is zero).
// Configuration: write skip_offset (index 0) or expected_crc (index 1) through
// cfg_we/cfg_index/cfg_data while no file is in flight.
//
// Throughput is one byte per cycle while the output slot is free for a last
// byte: the eight CRC bit steps sit in one combinational stage between the
// input beat register and the state; results go to the output register.
// When the receiver stalls, the result holds in the output register and the
// input keeps taking bytes; only a second last byte waits for the slot.
// Reset clears the running CRC to all ones, the byte position and both
// configuration registers to zero, and empties both stages.
module crc32_check_with_skip_window
    import ccsw_pkg::*;
#(
    parameter int POSITION_BITS = 40
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      crc_value,
    output logic [1:0]       status,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [SKIP_W-1:0] skip_offset_reg;
    logic [CRC_W-1:0]  expected_crc_reg;
    logic              out_free;
    ccsw_push_t        push;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_offset_reg  <= '0;
            expected_crc_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SKIP_OFFSET:  skip_offset_reg  <= cfg_data[SKIP_W-1:0];
                REG_EXPECTED_CRC: expected_crc_reg <= cfg_data[CRC_W-1:0];
                default:          ;
            endcase
        end
    end

    ccsw_crc_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .skip_offset  (skip_offset_reg),
        .expected_crc (expected_crc_reg),
        .out_free     (out_free),
        .push         (push)
    );

    ccsw_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .crc_value (crc_value),
        .status    (status)
    );

endmodule

// File: rtl/core/ccsw_checker.sv
module ccsw_checker
    import ccsw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] crc_value,
    input logic [1:0]  status
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(crc_value) && $stable(status))
        else $error("result beat changed while stalled");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_MATCH || status == STATUS_MISMATCH ||
                       status == STATUS_SKIPPED))
        else $error("undefined status code");

    // An empty output stage never backs up the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A new result traces back to an accepted last byte
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && last_byte, 2))
        else $error("result without a matching last byte");

endmodule

bind crc32_check_with_skip_window ccsw_checker u_ccsw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .crc_value (crc_value),
    .status    (status)
);
